// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon block: widths, store
// sizes, op codes, register indexes, controller states, command and status.
// ----------------------------------------------------------------------------
package pip_pkg;

  // store sizes
  localparam int MAX_VERTICES = 256;
  localparam int MAX_RINGS    = 16;
  localparam int VADDR_W      = $clog2(MAX_VERTICES);
  localparam int VCNT_W       = VADDR_W + 1;
  localparam int RING_W       = $clog2(MAX_RINGS);
  localparam int RCNT_W       = RING_W + 1;

  // coordinate widths, degrees: lat Q8.22, lon Q9.22
  localparam int LAT_W  = 30;
  localparam int LON_W  = 31;
  localparam int DLAT_W = LAT_W + 1;
  localparam int DLON_W = LON_W + 1;
  localparam int PROD_W = DLAT_W + DLON_W;

  // port widths
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 32;

  // sector register reset values
  localparam logic signed [LAT_W-1:0] SECTOR_LAT_MIN_RST = -30'sd377487360;
  localparam logic signed [LAT_W-1:0] SECTOR_LAT_MAX_RST =  30'sd377487360;
  localparam logic signed [LON_W-1:0] SECTOR_LON_MIN_RST = -31'sd754974720;
  localparam logic signed [LON_W-1:0] SECTOR_LON_MAX_RST =  31'sd754974720;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAT_MIN = 8'd0,
    CFG_LAT_MAX = 8'd1,
    CFG_LON_MIN = 8'd2,
    CFG_LON_MAX = 8'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QSTART,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;      // latch query point
    logic clear;        // empty the polygon
    logic append;       // store one vertex
    logic walk_init;    // start the edge walk, clear accumulators
    logic walk_step;    // issue one store read
    logic acc_clear;    // clear accumulators, no walk
    logic result_load;  // load the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic go;           // point inside sector and at least one ring
    logic last_issue;   // this step reads the final vertex
    logic pipe_busy;    // edge pipeline still holds work
    logic out_free;     // output register can take a word
  } stat_t;

endpackage

// ===== rtl/pip_ctrl.sv =====
// ----------------------------------------------------------------------------
// pip_ctrl
// Controller of the point-in-polygon block: decodes input words, sequences
// a query through sector check, edge walk, pipeline drain and result load.
// ----------------------------------------------------------------------------
module pip_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  input  logic [pip_pkg::OP_W-1:0]   op,
  output logic                       s_tready,
  input  pip_pkg::stat_t             stat,
  output pip_pkg::cmd_t              cmd
);
  import pip_pkg::*;

  state_t state;
  state_t state_next;
  op_t    op_code;

  assign op_code = op_t'(op);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid && op_code == OP_QUERY) state_next = ST_QSTART;
      end
      ST_QSTART: begin
        state_next = stat.go ? ST_WALK : ST_DONE;
      end
      ST_WALK: begin
        if (stat.last_issue) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_tready = 1'b0;
    cmd      = '0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        case (op_code)
          OP_CLEAR:  cmd.clear   = s_tvalid;
          OP_APPEND: cmd.append  = s_tvalid;
          OP_QUERY:  cmd.capture = s_tvalid;
          default:   ;
        endcase
      end
      ST_QSTART: begin
        cmd.walk_init = stat.go;
        cmd.acc_clear = !stat.go;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
      end
      ST_DRAIN: ;
      ST_DONE: begin
        cmd.result_load = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/pip_dp.sv =====
// ----------------------------------------------------------------------------
// pip_dp
// Datapath of the point-in-polygon block: sector registers, vertex store and
// ring end table, walk address generator, edge-crossing pipeline, and the
// output register.
// ----------------------------------------------------------------------------
module pip_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  pip_pkg::cmd_t                       cmd,
  output pip_pkg::stat_t                      stat,
  input  logic signed [pip_pkg::LAT_W-1:0]    in_lat,
  input  logic signed [pip_pkg::LON_W-1:0]    in_lon,
  input  logic                                in_ring_last,
  input  logic                                cfg_valid,
  input  logic [pip_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pip_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                m_tready,
  output logic                                m_tvalid,
  output logic [pip_pkg::OUT_TDATA_W-1:0]     m_tdata
);
  import pip_pkg::*;

  // sector bounds
  logic signed [LAT_W-1:0] lat_min, lat_max;
  logic signed [LON_W-1:0] lon_min, lon_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_min <= SECTOR_LAT_MIN_RST;
      lat_max <= SECTOR_LAT_MAX_RST;
      lon_min <= SECTOR_LON_MIN_RST;
      lon_max <= SECTOR_LON_MAX_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_LAT_MIN: lat_min <= cfg_data[LAT_W-1:0];
        CFG_LAT_MAX: lat_max <= cfg_data[LAT_W-1:0];
        CFG_LON_MIN: lon_min <= cfg_data[LON_W-1:0];
        CFG_LON_MAX: lon_max <= cfg_data[LON_W-1:0];
        default: ;
      endcase
    end
  end

  // query point
  logic signed [LAT_W-1:0] p_lat;
  logic signed [LON_W-1:0] p_lon;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      p_lat <= in_lat;
      p_lon <= in_lon;
    end
  end

  // polygon bookkeeping
  logic [VCNT_W-1:0] vertex_total;
  logic [VCNT_W-1:0] open_start;
  logic [RCNT_W-1:0] ring_total;
  logic              overflow_seen;
  logic [VCNT_W-1:0] vt_inc;
  logic [VCNT_W-1:0] vt_after;
  logic              room_v;
  logic              rings_full;
  logic              close_ring;

  always_comb begin
    vt_inc     = vertex_total + VCNT_W'(1);
    room_v     = vertex_total < VCNT_W'(MAX_VERTICES);
    rings_full = ring_total >= RCNT_W'(MAX_RINGS);
    vt_after   = room_v ? vt_inc : vertex_total;
    close_ring = in_ring_last && (vt_after > open_start);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      vertex_total  <= '0;
      open_start    <= '0;
      ring_total    <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.append) begin
      if (rings_full) begin
        overflow_seen <= 1'b1;
      end else begin
        if (room_v) begin
          vertex_total <= vt_inc;
        end else begin
          overflow_seen <= 1'b1;
        end
        if (close_ring) begin
          ring_total <= ring_total + RCNT_W'(1);
          open_start <= vt_after;
        end
      end
    end
  end

  // walk address generator
  logic [VADDR_W-1:0] vaddr;
  logic [RING_W-1:0]  ring_idx;
  logic [VCNT_W-1:0]  ring_end;
  logic               phase_prev;
  logic [RING_W-1:0]  tbl_addr;
  logic [VCNT_W-1:0]  tbl_rd;
  logic [VCNT_W-1:0]  prev_full;
  logic [VCNT_W-1:0]  vnext;
  logic [RCNT_W-1:0]  ring_next;
  logic               edge_last;
  logic [VADDR_W-1:0] rd_addr;

  // vertex store and ring end table
  logic [LAT_W-1:0]  mem_lat [MAX_VERTICES];
  logic [LON_W-1:0]  mem_lon [MAX_VERTICES];
  logic [VCNT_W-1:0] ring_end_tbl [MAX_RINGS];
  logic signed [LAT_W-1:0] rd_lat;
  logic signed [LON_W-1:0] rd_lon;

  // table lookup: entry 0 while a query is taken, else the ring after the
  // current one; every ring first reads its closing vertex in a step of its
  // own, so the registered entry is ready before the ring's last edge
  always_comb begin
    tbl_addr  = cmd.capture ? '0 : ring_idx + RING_W'(1);
    prev_full = ring_end - VCNT_W'(1);
    vnext     = {1'b0, vaddr} + VCNT_W'(1);
    ring_next = {1'b0, ring_idx} + RCNT_W'(1);
    edge_last = vnext == ring_end;
    rd_addr   = phase_prev ? prev_full[VADDR_W-1:0] : vaddr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vaddr      <= '0;
      ring_idx   <= '0;
      ring_end   <= '0;
      phase_prev <= 1'b1;
    end else if (cmd.walk_init) begin
      vaddr      <= '0;
      ring_idx   <= '0;
      ring_end   <= tbl_rd;
      phase_prev <= 1'b1;
    end else if (cmd.walk_step) begin
      if (phase_prev) begin
        phase_prev <= 1'b0;
      end else begin
        vaddr <= vnext[VADDR_W-1:0];
        if (edge_last) begin
          ring_idx   <= ring_idx + RING_W'(1);
          ring_end   <= tbl_rd;
          phase_prev <= 1'b1;
        end
      end
    end
  end

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (cmd.append && !rings_full && room_v) begin
      mem_lat[vertex_total[VADDR_W-1:0]] <= in_lat;
      mem_lon[vertex_total[VADDR_W-1:0]] <= in_lon;
    end
    if (cmd.append && !rings_full && close_ring) begin
      ring_end_tbl[ring_total[RING_W-1:0]] <= vt_after;
    end
    tbl_rd <= ring_end_tbl[tbl_addr];
    if (cmd.walk_step) begin
      rd_lat <= mem_lat[rd_addr];
      rd_lon <= mem_lon[rd_addr];
    end
  end

  // read stage tags
  logic rv, r_prev, r_end, r_outer;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else begin
      rv <= cmd.walk_step;
    end
    r_prev  <= phase_prev;
    r_end   <= !phase_prev && edge_last;
    r_outer <= ring_idx == '0;
  end

  // edge stage 1: compares and differences
  logic signed [LAT_W-1:0]  a_lat;
  logic signed [LON_W-1:0]  a_lon;
  logic                     ev, e_end, e_outer, e_deg, e_eq, e_str, e_dpos;
  logic signed [DLAT_W-1:0] e_dlat, e_dp;
  logic signed [DLON_W-1:0] e_dx, e_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ev <= 1'b0;
    end else begin
      ev <= rv && !r_prev;
    end
    if (rv) begin
      a_lat <= rd_lat;
      a_lon <= rd_lon;
    end
    e_end   <= r_end;
    e_outer <= r_outer;
    e_deg   <= (a_lat == rd_lat) && (a_lon == rd_lon);
    e_eq    <= (a_lat == p_lat) && (a_lon == p_lon);
    e_str   <= ((a_lat <= p_lat) && (p_lat < rd_lat)) ||
               ((rd_lat <= p_lat) && (p_lat < a_lat));
    e_dpos  <= rd_lat > a_lat;
    e_dlat  <= DLAT_W'(rd_lat) - DLAT_W'(a_lat);
    e_dp    <= DLAT_W'(p_lat) - DLAT_W'(a_lat);
    e_dx    <= DLON_W'(p_lon) - DLON_W'(a_lon);
    e_dy    <= DLON_W'(rd_lon) - DLON_W'(a_lon);
  end

  // edge stage 2: cross products
  logic                     mv, m_end, m_outer, m_cnt_en, m_eq_en, m_dpos;
  logic signed [PROD_W-1:0] m_lhs, m_rhs;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else begin
      mv <= ev;
    end
    m_end    <= e_end;
    m_outer  <= e_outer;
    m_cnt_en <= e_str && !e_deg;
    m_eq_en  <= e_eq && !e_deg;
    m_dpos   <= e_dpos;
    m_lhs    <= PROD_W'(e_dx) * PROD_W'(e_dlat);
    m_rhs    <= PROD_W'(e_dy) * PROD_W'(e_dp);
  end

  // edge stage 3: crossing parity and ring verdicts
  logic parity, ringhit, outer_in, hole_any;
  logic hit, par_n, rh_n;

  always_comb begin
    hit   = m_dpos ? (m_lhs <= m_rhs) : (m_lhs >= m_rhs);
    par_n = parity ^ (m_cnt_en && hit);
    rh_n  = ringhit || m_eq_en;
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init || cmd.acc_clear) begin
      parity   <= 1'b0;
      ringhit  <= 1'b0;
      outer_in <= 1'b0;
      hole_any <= 1'b0;
    end else if (mv) begin
      if (m_end) begin
        parity  <= 1'b0;
        ringhit <= 1'b0;
        if (m_outer) begin
          outer_in <= par_n || rh_n;
        end else if (par_n || rh_n) begin
          hole_any <= 1'b1;
        end
      end else begin
        parity  <= par_n;
        ringhit <= rh_n;
      end
    end
  end

  // output register
  logic out_inside, out_over;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.result_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (cmd.result_load) begin
      out_inside <= outer_in && !hole_any;
      out_over   <= overflow_seen;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W-2){1'b0}}, out_over, out_inside};

  // status
  always_comb begin
    stat.go         = (p_lat >= lat_min) && (p_lat <= lat_max) &&
                      (p_lon >= lon_min) && (p_lon <= lon_max) &&
                      (ring_total != '0);
    stat.last_issue = !phase_prev && edge_last && (ring_next == ring_total);
    stat.pipe_busy  = rv || ev || mv;
    stat.out_free   = !m_tvalid || m_tready;
  end

endmodule

// ===== rtl/point_in_polygon_with_holes.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_with_holes
// Even-odd point-in-polygon test over stored rings, ring 0 outer, later
// rings holes, with a configurable bounding sector.
// ----------------------------------------------------------------------------
// Clear and append words are applied as they are taken. A query walks the
// vertices of the closed rings (up to 256 vertices in up to 16 rings): the
// single read port of the vertex store supplies one vertex per cycle, plus
// one read per ring for its closing vertex, followed by a three-stage edge
// pipeline. A query outside the sector or with no ring skips the walk and
// goes straight to the result. Results are registered, so the next word is
// taken while a result waits on m_tready.
// The config port is always ready and must only be written while idle.
// ----------------------------------------------------------------------------
module point_in_polygon_with_holes (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [pip_pkg::IN_TDATA_W-1:0]       s_tdata,  // lat[29:0], lon[60:30], zero pad
  input  logic [pip_pkg::OP_W-1:0]             s_tuser,  // op[1:0]
  input  logic                                 s_tlast,  // ring_last
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [pip_pkg::OUT_TDATA_W-1:0]      m_tdata,  // inside_res[0], overflowed[1], pad
  // config write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pip_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pip_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pip_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  logic signed [LAT_W-1:0] in_lat;
  logic signed [LON_W-1:0] in_lon;

  assign in_lat    = s_tdata[LAT_W-1:0];
  assign in_lon    = s_tdata[LAT_W+LON_W-1:LAT_W];
  assign cfg_ready = 1'b1;

  pip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pip_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_lat       (in_lat),
    .in_lon       (in_lon),
    .in_ring_last (s_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .m_tdata      (m_tdata)
  );

endmodule
